// File: rtl/rws_pkg.sv
// shared types and constants for the roulette wheel selector
package rws_pkg;

  // default number of wheel entries the store holds
  localparam int unsigned DefaultMaxEntries = 64;

  // field widths fixed by the interface
  localparam int unsigned FuncW      = 1;
  localparam int unsigned CfgW       = 7;
  localparam int unsigned IdxInW     = 6;
  localparam int unsigned OperandW   = 16;
  localparam int unsigned SumW       = 22;
  localparam int unsigned ProdW      = OperandW + SumW;
  localparam int unsigned SelW       = 6;

  // entry_count value after reset
  localparam logic [CfgW-1:0] EntryCountReset = 7'd64;

  // command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // item function codes
  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD = 1'b0,
    FUNC_SPIN = 1'b1
  } func_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_SCAN
  } back_state_e;

  // classified command: kind plus weight (load) or random fraction (spin)
  typedef struct packed {
    func_e                kind;
    logic [OperandW-1:0]  operand;
  } cmd_t;

endpackage

// File: rtl/rws_front.sv
// front end: takes items, drops loads beyond the store, queues commands
module rws_front #(
  parameter int unsigned MaxEntries = rws_pkg::DefaultMaxEntries
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [rws_pkg::FuncW-1:0]         func_i,
  input  logic [rws_pkg::IdxInW-1:0]        weight_index_i,
  input  logic [rws_pkg::OperandW-1:0]      weight_i,
  input  logic [rws_pkg::OperandW-1:0]      random_fraction_i,
  output logic                              cmd_valid_o,
  output rws_pkg::cmd_t                     cmd_o,
  output logic [$clog2(MaxEntries)-1:0]     cmd_idx_o,
  input  logic                              cmd_pop_i
);
  import rws_pkg::*;

  localparam int unsigned AW    = $clog2(MaxEntries);
  localparam int unsigned CntW  = $clog2(MaxEntries + 1);
  localparam int unsigned ExtW  = (CntW > CfgW) ? CntW : CfgW;

  cmd_t             q_cmd_q [QueueDepth];
  logic [AW-1:0]    q_idx_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  logic             full;
  logic             accept;
  logic             push;
  logic             pop;
  logic             idx_in_range;
  logic [ExtW-1:0]  idx_ext;
  cmd_t             new_cmd;

  // classify the incoming item
  always_comb begin
    idx_ext        = ExtW'(weight_index_i);
    idx_in_range   = idx_ext < ExtW'(MaxEntries);
    new_cmd.kind   = func_e'(func_i);
    new_cmd.operand = (func_e'(func_i) == FUNC_SPIN) ? random_fraction_i : weight_i;
  end

  // transfer in; loads beyond the store are taken and discarded
  assign full   = count_q == QCntW'(QueueDepth);
  assign busy_o = full;
  assign accept = start_i && !full;
  assign push   = accept && ((new_cmd.kind == FUNC_SPIN) || idx_in_range);
  assign pop    = cmd_pop_i && (count_q != '0);

  // queue pointers and fill level
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_cmd_q[wr_ptr_q] <= new_cmd;
      q_idx_q[wr_ptr_q] <= idx_ext[AW-1:0];
    end
  end

  // head of queue to the back end
  assign cmd_valid_o = count_q != '0;
  assign cmd_o       = q_cmd_q[rd_ptr_q];
  assign cmd_idx_o   = q_idx_q[rd_ptr_q];

endmodule

// File: rtl/rws_back.sv
// back end: cumulative sum store, load update, spin scaling and scan
module rws_back #(
  parameter int unsigned MaxEntries = rws_pkg::DefaultMaxEntries
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              entry_count_we_i,
  input  logic [rws_pkg::CfgW-1:0]          entry_count_i,
  input  logic                              cmd_valid_i,
  input  rws_pkg::cmd_t                     cmd_i,
  input  logic [$clog2(MaxEntries)-1:0]     cmd_idx_i,
  output logic                              cmd_pop_o,
  output logic                              done_o,
  output logic [rws_pkg::SelW-1:0]          selected_index_o
);
  import rws_pkg::*;

  localparam int unsigned AW    = $clog2(MaxEntries);
  localparam int unsigned CntW  = $clog2(MaxEntries + 1);
  localparam int unsigned ExtW  = (CntW > CfgW) ? CntW : CfgW;

  back_state_e       state_q, state_d;
  logic [CfgW-1:0]   entry_count_q;
  cmd_t              op_q;
  logic [AW-1:0]     op_idx_q;
  logic [AW-1:0]     last_q;
  logic [SumW-1:0]   d_q;
  logic [AW-1:0]     cmp_q;
  logic [AW-1:0]     count_q;
  logic              done_q, done_d;
  logic [SelW-1:0]   sel_q, sel_d;

  logic [SumW-1:0]   mem_q [MaxEntries];
  logic [SumW-1:0]   rdata_q;
  logic [AW-1:0]     raddr;
  logic              mem_we;
  logic [SumW-1:0]   wdata;

  logic [ExtW-1:0]   cnt_ext;
  logic [ExtW-1:0]   cnt_m1;
  logic [AW-1:0]     n_m1;
  logic [SumW:0]     load_sum;
  logic [SumW-1:0]   prev_sum;
  logic [ProdW-1:0]  product;
  logic              hit;
  logic              scan_last;
  logic [AW-1:0]     count_next;
  logic [ExtW-1:0]   count_ext;

  // entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= EntryCountReset;
    end else if (entry_count_we_i) begin
      entry_count_q <= entry_count_i;
    end
  end

  // last index in use: zero acts as one, large values clamp to the store
  always_comb begin
    cnt_ext = ExtW'(entry_count_q);
    cnt_m1  = cnt_ext - ExtW'(1);
    if (cnt_ext == '0) begin
      n_m1 = '0;
    end else if (cnt_ext > ExtW'(MaxEntries)) begin
      n_m1 = AW'(MaxEntries - 1);
    end else begin
      n_m1 = cnt_m1[AW-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.kind == FUNC_SPIN) ? ST_MUL : ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_MUL: begin
        state_d = (last_q == '0) ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath values
  always_comb begin
    prev_sum   = (op_idx_q == '0) ? '0 : rdata_q;
    load_sum   = {1'b0, prev_sum} + (SumW + 1)'(op_q.operand);
    wdata      = load_sum[SumW] ? {SumW{1'b1}} : load_sum[SumW-1:0];
    product    = ProdW'(op_q.operand) * ProdW'(rdata_q);
    hit        = rdata_q <= d_q;
    scan_last  = cmp_q == (last_q - AW'(1));
    count_next = count_q + AW'(hit);
    count_ext  = ExtW'(count_next);
  end

  // sequencer outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    raddr     = '0;
    done_d    = 1'b0;
    sel_d     = sel_q;
    case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        raddr     = (cmd_i.kind == FUNC_SPIN) ? n_m1 : cmd_idx_i - AW'(1);
      end
      ST_LOAD: mem_we = 1'b1;
      ST_MUL: begin
        raddr = '0;
        if (last_q == '0) begin
          done_d = 1'b1;
          sel_d  = '0;
        end
      end
      ST_SCAN: begin
        raddr = cmp_q + AW'(1);
        if (scan_last) begin
          done_d = 1'b1;
          sel_d  = count_ext[SelW-1:0];
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // operand, scan and result registers
  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    if (cmd_pop_o) begin
      op_q     <= cmd_i;
      op_idx_q <= cmd_idx_i;
      last_q   <= n_m1;
    end
    if (state_q == ST_MUL) begin
      d_q     <= product[ProdW-1:OperandW];
      cmp_q   <= '0;
      count_q <= '0;
    end else if (state_q == ST_SCAN) begin
      cmp_q   <= cmp_q + AW'(1);
      count_q <= count_next;
    end
  end

  // cumulative sum store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[op_idx_q] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign done_o           = done_q;
  assign selected_index_o = sel_q;

endmodule

// File: rtl/roulette_wheel_select.sv
// top level of the roulette wheel selector
//
// Usage: items enter on start_i while busy_o is low. func_i low loads one
// weight at weight_index_i; loads come in ascending index order and each
// stores the running cumulative sum, saturated at 22 bits. func_i high spins
// the wheel with random_fraction_i; the spin scales the fraction by the
// wheel total and returns on selected_index_o the count of cumulative entries
// among the first entry_count-1 that do not exceed the scaled value.
// Each spin result is shown for one cycle with done_o high; the receiver
// cannot stall it. Loads give no result.
// The user must write entry_count with entry_count_we_i only while the block
// is idle; the block itself does not enforce this. entry_count resets to 64.
// Reset empties the command queue; the sum store holds no defined data
// until loaded.
// Sequencing: a two-entry queue sits between intake and execution. The
// execute side does a load as a store read of the previous sum and a store
// write, and a spin as one store read for the total, one multiply, then one
// store entry compared per cycle over a single read port.
module roulette_wheel_select #(
  parameter int unsigned MaxEntries = rws_pkg::DefaultMaxEntries
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [rws_pkg::FuncW-1:0]         func_i,
  input  logic [rws_pkg::IdxInW-1:0]        weight_index_i,
  input  logic [rws_pkg::OperandW-1:0]      weight_i,
  input  logic [rws_pkg::OperandW-1:0]      random_fraction_i,
  input  logic                              entry_count_we_i,
  input  logic [rws_pkg::CfgW-1:0]          entry_count_i,
  output logic                              done_o,
  output logic [rws_pkg::SelW-1:0]          selected_index_o
);
  import rws_pkg::*;

  localparam int unsigned AW = $clog2(MaxEntries);

  logic           cmd_valid;
  cmd_t           cmd;
  logic [AW-1:0]  cmd_idx;
  logic           cmd_pop;

  // intake and command queue
  rws_front #(
    .MaxEntries (MaxEntries)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .func_i            (func_i),
    .weight_index_i    (weight_index_i),
    .weight_i          (weight_i),
    .random_fraction_i (random_fraction_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_idx_o         (cmd_idx),
    .cmd_pop_i         (cmd_pop)
  );

  // execution
  rws_back #(
    .MaxEntries (MaxEntries)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .entry_count_we_i (entry_count_we_i),
    .entry_count_i    (entry_count_i),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_idx_i        (cmd_idx),
    .cmd_pop_o        (cmd_pop),
    .done_o           (done_o),
    .selected_index_o (selected_index_o)
  );

endmodule

// File: rtl/rws_checker.sv
// port-level checks for the roulette wheel selector, bound to the top level
module rws_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_o,
  input  logic done_o
);

  // reset holds the block empty and quiet from the edge after it is seen
  assert property (@(posedge clk_i) !rst_ni |=> (!busy_o && !done_o))
    else $error("busy or result strobe during reset");

  // every spin passes the idle and multiply states before its result, so results never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobes in consecutive cycles");

  // the queue can only fill after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && !busy_o))
    else $error("busy rose without an input transfer");

endmodule

bind roulette_wheel_select rws_checker u_rws_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
